>>> rtl/assert_macros.svh
// assertion helpers used by the frame decoder unit
// each helper has a real body for simulation and an empty one for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define GSFD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("gsfd assertion failed");
`define GSFD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("gsfd forbidden condition seen");
`else
`define GSFD_ASSERT(lbl, clk, rst_n, prop)
`define GSFD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

>>> rtl/gsfd_pkg.sv
// ---------------------------------------------------------------------------
// gsfd_pkg
// shared constants, types and the d-pad to hat table for the frame decoder
// ---------------------------------------------------------------------------
package gsfd_pkg;

    localparam logic [7:0] MARK_HEADER  = 8'h80;
    localparam logic [7:0] MARK_SERVO   = 8'h40;
    localparam logic [7:0] MARK_IGNORE  = 8'hFF;
    localparam logic [7:0] MARK_RELEASE = 8'h80;

    localparam int unsigned NUM_BTN  = 9;
    localparam int unsigned HOME_BIT = 8;

    localparam logic [3:0] HAT_NEUTRAL = 4'd8;

    // position inside the current frame
    typedef enum logic [1:0] {
        FC_IDLE  = 2'd0,
        FC_FIRST = 2'd1,
        FC_BTN   = 2'd2,
        FC_DONE  = 2'd3
    } t_frame_pos;

    // frame completion reported by the framer to the decoder
    typedef struct packed {
        logic       servo_done;
        logic       long_done;
        logic [7:0] button_byte;
        logic [7:0] second_byte;
    } t_frame_evt;

    // code is {up, right, down, left}
    function automatic logic [3:0] hat_of(input logic [3:0] code);
        logic [3:0] hat;
        unique case (code)
            4'b1000: hat = 4'd0;
            4'b1100: hat = 4'd1;
            4'b0100: hat = 4'd2;
            4'b0110: hat = 4'd3;
            4'b0010: hat = 4'd4;
            4'b0011: hat = 4'd5;
            4'b0001: hat = 4'd6;
            4'b1001: hat = 4'd7;
            default: hat = HAT_NEUTRAL;
        endcase
        return hat;
    endfunction

endpackage

>>> rtl/gamepad_serial_frame_decoder_unit.sv
// ---------------------------------------------------------------------------
// gamepad_serial_frame_decoder_unit
// serial byte framer and gamepad state decoder
// ---------------------------------------------------------------------------
// input channel: one received byte per request on i_byte_in, taken when
// i_valid is high and o_stall is low. output channel: the held gamepad state
// (nine buttons and hat) on o_btn_* and o_hat_dir, taken when o_valid is high
// and i_stall is low. one result leaves per completed frame: on the '@'
// byte of a one-byte frame and on the last byte of a three-byte frame; all
// other bytes, 0xFF included, give none.
// a byte is registered on entry, then framed and decoded into the result
// register; a stalled receiver can hold it in the entry register. one byte
// per cycle is accepted while o_stall is low, set by the single framer/decode
// stage between the input and result registers.
// when the receiver stalls, the result holds; the entry register then fills
// and o_stall rises until the result is taken.
// reset (i_rst_n low, synchronous) closes any open frame, releases all
// buttons, sets the hat to neutral and empties both registers.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gamepad_serial_frame_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_byte_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_btn_a,
    output logic       o_btn_b,
    output logic       o_btn_x,
    output logic       o_btn_y,
    output logic       o_btn_l,
    output logic       o_btn_r,
    output logic       o_btn_zr,
    output logic       o_btn_plus,
    output logic       o_btn_home,
    output logic [3:0] o_hat_dir
);

    logic                         r_in_valid;
    logic [7:0]                   r_in_byte;
    logic                         r_out_valid;
    logic [gsfd_pkg::NUM_BTN-1:0] r_out_btn;
    logic [3:0]                   r_out_hat;
    logic                         step;
    logic                         in_take;
    gsfd_pkg::t_frame_evt         evt;
    logic [gsfd_pkg::NUM_BTN-1:0] n_buttons;
    logic [3:0]                   n_hat;

    // the stage moves on when the result slot is free or being taken
    assign step    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !step;
    assign in_take = i_valid && !o_stall;

    gsfd_framer u_framer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_evt   (evt)
    );

    gsfd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (evt),
        .o_n_buttons (n_buttons),
        .o_n_hat     (n_hat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take || step) begin
                r_in_valid <= in_take;
            end
            if (step) begin
                r_out_valid <= evt.servo_done || evt.long_done;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_take) begin
            r_in_byte <= i_byte_in;
        end
        if (step && (evt.servo_done || evt.long_done)) begin
            r_out_btn <= n_buttons;
            r_out_hat <= n_hat;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_btn_a    = r_out_btn[0];
    assign o_btn_b    = r_out_btn[1];
    assign o_btn_x    = r_out_btn[2];
    assign o_btn_y    = r_out_btn[3];
    assign o_btn_l    = r_out_btn[4];
    assign o_btn_r    = r_out_btn[5];
    assign o_btn_zr   = r_out_btn[6];
    assign o_btn_plus = r_out_btn[7];
    assign o_btn_home = r_out_btn[gsfd_pkg::HOME_BIT];
    assign o_hat_dir  = r_out_hat;

    `GSFD_ASSERT(a_servo_sets_home, i_clk, i_rst_n, (step && evt.servo_done) |=> (o_valid && o_btn_home))
    `GSFD_ASSERT(a_long_clears_home, i_clk, i_rst_n, (step && evt.long_done) |=> (o_valid && !o_btn_home))
    `GSFD_ASSERT_NEVER(a_evt_exclusive, i_clk, i_rst_n, evt.servo_done && evt.long_done)
    `GSFD_ASSERT_NEVER(a_hat_range, i_clk, i_rst_n, o_valid && (o_hat_dir > gsfd_pkg::HAT_NEUTRAL))
    `GSFD_ASSERT(a_ignore_no_result, i_clk, i_rst_n, (step && r_in_byte == gsfd_pkg::MARK_IGNORE) |=> !o_valid)

endmodule

>>> rtl/gsfd_framer.sv
// ---------------------------------------------------------------------------
// gsfd_framer
// tracks the frame position and reports completed frames
// ---------------------------------------------------------------------------
module gsfd_framer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_byte,
    output gsfd_pkg::t_frame_evt  o_evt
);

    gsfd_pkg::t_frame_pos r_fc;
    gsfd_pkg::t_frame_pos n_fc;
    logic                 r_servo;
    logic                 n_servo;
    logic [7:0]           r_button_byte;
    logic [7:0]           n_button_byte;
    gsfd_pkg::t_frame_pos fc_eff;
    logic                 take;

    assign take = i_step && (i_byte != gsfd_pkg::MARK_IGNORE);

    // a finished frame reopens on the next byte
    always_comb begin
        fc_eff = r_fc;
        if ((r_fc == gsfd_pkg::FC_FIRST && r_servo) || r_fc == gsfd_pkg::FC_DONE) begin
            fc_eff = gsfd_pkg::FC_IDLE;
        end
    end

    // next state
    always_comb begin
        n_fc          = r_fc;
        n_servo       = r_servo;
        n_button_byte = r_button_byte;
        if (take) begin
            n_fc = fc_eff;
            unique case (fc_eff)
                gsfd_pkg::FC_IDLE: begin
                    if (i_byte == gsfd_pkg::MARK_HEADER ||
                        i_byte == gsfd_pkg::MARK_SERVO) begin
                        n_servo = (i_byte == gsfd_pkg::MARK_SERVO);
                        n_fc    = gsfd_pkg::FC_FIRST;
                    end
                end
                gsfd_pkg::FC_FIRST: begin
                    n_button_byte = i_byte;
                    n_fc          = gsfd_pkg::FC_BTN;
                end
                gsfd_pkg::FC_BTN: begin
                    n_fc = gsfd_pkg::FC_DONE;
                end
                default: begin
                    n_fc = gsfd_pkg::FC_IDLE;
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        o_evt = '{servo_done: 1'b0, long_done: 1'b0,
                  button_byte: r_button_byte, second_byte: i_byte};
        if (take) begin
            unique case (fc_eff)
                gsfd_pkg::FC_IDLE: begin
                    o_evt.servo_done = (i_byte == gsfd_pkg::MARK_SERVO);
                end
                gsfd_pkg::FC_BTN: begin
                    o_evt.long_done = 1'b1;
                end
                default: begin
                    o_evt.long_done = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc    <= gsfd_pkg::FC_IDLE;
            r_servo <= 1'b0;
        end else begin
            r_fc    <= n_fc;
            r_servo <= n_servo;
        end
        r_button_byte <= n_button_byte;
    end

endmodule

>>> rtl/gsfd_decode.sv
// ---------------------------------------------------------------------------
// gsfd_decode
// keeps the held buttons and hat and updates them on completed frames
// ---------------------------------------------------------------------------
module gsfd_decode (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  gsfd_pkg::t_frame_evt               i_evt,
    output logic [gsfd_pkg::NUM_BTN-1:0]       o_n_buttons,
    output logic [3:0]                         o_n_hat
);

    logic [gsfd_pkg::NUM_BTN-1:0] r_buttons;
    logic [3:0]                   r_hat;
    logic [3:0]                   dpad;

    always_comb begin
        o_n_buttons = r_buttons;
        o_n_hat     = r_hat;
        dpad        = {i_evt.second_byte[4], i_evt.second_byte[3],
                       i_evt.second_byte[5], i_evt.second_byte[2]};
        priority if (i_evt.servo_done) begin
            o_n_buttons[gsfd_pkg::HOME_BIT] = 1'b1;
        end else if (i_evt.long_done) begin
            o_n_buttons = '0;
            o_n_hat     = gsfd_pkg::HAT_NEUTRAL;
            if (i_evt.button_byte != gsfd_pkg::MARK_RELEASE) begin
                o_n_buttons[5:0] = i_evt.button_byte[5:0];
            end
            if (i_evt.second_byte != gsfd_pkg::MARK_RELEASE) begin
                o_n_buttons[7:6] = i_evt.second_byte[1:0];
                o_n_hat          = gsfd_pkg::hat_of(dpad);
            end else begin
                o_n_hat = gsfd_pkg::hat_of(4'b0000);
            end
        end else begin
            o_n_buttons = r_buttons;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buttons <= '0;
            r_hat     <= gsfd_pkg::HAT_NEUTRAL;
        end else begin
            r_buttons <= o_n_buttons;
            r_hat     <= o_n_hat;
        end
    end

endmodule
